FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the server assignment block.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, switched off while reset is low.
`define EFSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define EFSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/efsa_pkg.sv
// Shared constants and control types for the earliest-free server assignment block.
// No dependencies; imported by efsa_ftmem, the top level and the bench.
package efsa_pkg;

  localparam int unsigned MAX_SERVERS_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 20;

  localparam int unsigned CFG_W  = 5;   // server_count register
  localparam int unsigned SRV_W  = 4;   // server_index / assigned_server
  localparam int unsigned SVC_W  = 16;  // service_time
  localparam int unsigned WAIT_W = 36;  // wait_time

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // Finish-time store controls issued by the sequencer.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ft_ctrl_t;

endpackage

FILE: rtl/efsa_ftmem.sv
// Finish-time memory with registered read and the running-minimum compare unit.
// Depends on efsa_pkg (ft_ctrl_t).
module efsa_ftmem import efsa_pkg::*; #(
  parameter int unsigned MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int unsigned FT_W        = POSITION_BITS_DEF + SVC_W,
  localparam int unsigned IDX_W      = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ft_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [FT_W-1:0]  wr_data_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [IDX_W-1:0] best_idx_o,
  output logic [FT_W-1:0]  best_val_o
);

  logic [FT_W-1:0]  ft_mem [MAX_SERVERS];
  logic [FT_W-1:0]  rd_data_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [FT_W-1:0]  best_val_q;
  logic             take;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      ft_mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= ft_mem[rd_addr_i];
    rd_idx_q  <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.rd_en;
    end
  end

  // Entry zero restarts the scan; strict less keeps the lower index on a tie.
  assign take = rd_vld_q && ((rd_idx_q == '0) || (rd_data_q < best_val_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q <= rd_idx_q;
      best_val_q <= rd_data_q;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_val_o = best_val_q;

endmodule

FILE: rtl/earliest_free_server_assignment_unit.sv
// Earliest-free server assignment: a load writes the service table; the block stays ready.
// Query, no servers or position p below count n: result goes out once the output is free.
// Else p-n update rounds and a final one-entry-a-cycle minimum scan over the finish-time
// memory; not ready for a new request until the result is in the output.
// Async active-low reset clears sequencer, count register and output valid; tables need none.
`include "assert_macros.svh"
module earliest_free_server_assignment_unit import efsa_pkg::*; #(
  parameter int unsigned MAX_SERVERS   = MAX_SERVERS_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  localparam int unsigned IN_W  = ((SRV_W + SVC_W + POSITION_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((SRV_W + WAIT_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,     // server_count
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // server_index, service_time, position
  input  logic             s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // assigned_server, queue_delay
  output logic             m_axis_tuser    // no_servers
);

  localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int unsigned FT_W  = POSITION_BITS + SVC_W;
  localparam int unsigned CC_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned PC_W  = (POSITION_BITS > CNT_W) ? POSITION_BITS : CNT_W;
  localparam int unsigned EX_W  = (FT_W > WAIT_W) ? FT_W : WAIT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT_RD, ST_INIT_WR, ST_SCAN, ST_SCAN_DONE, ST_UPD_RD, ST_UPD_WR, ST_DONE
  } state_e;

  state_e                   state_q;
  logic [CFG_W-1:0]         count_q;
  logic [IDX_W-1:0]         cnt_q;
  logic [POSITION_BITS-1:0] rounds_q;
  logic                     direct_q;
  logic                     none_q;
  logic [IDX_W-1:0]         res_idx_q;
  logic                     m_valid_q;
  logic [SRV_W-1:0]         m_srv_q;
  logic [WAIT_W-1:0]        m_wait_q;
  logic                     m_none_q;

  logic [SVC_W-1:0]         tt_mem [MAX_SERVERS];
  logic [SVC_W-1:0]         tt_rd_q;
  logic [IDX_W-1:0]         tt_addr;

  logic [SRV_W-1:0]         in_idx;
  logic [SVC_W-1:0]         in_svc;
  logic [POSITION_BITS-1:0] in_pos;
  logic                     in_acc;
  logic [CC_W-1:0]          count_ext;
  logic [CNT_W-1:0]         n_act;
  logic                     cnt_last;
  logic                     out_free;

  ft_ctrl_t                 ft_ctrl;
  logic [IDX_W-1:0]         ft_wr_addr;
  logic [FT_W-1:0]          ft_wr_data;
  logic [IDX_W-1:0]         best_idx;
  logic [FT_W-1:0]          best_val;
  logic [EX_W-1:0]          best_ext;
  logic [WAIT_W-1:0]        best_sat;

  assign in_idx = s_axis_tdata[SRV_W-1:0];
  assign in_svc = s_axis_tdata[SRV_W+SVC_W-1:SRV_W];
  assign in_pos = s_axis_tdata[SRV_W+SVC_W+POSITION_BITS-1:SRV_W+SVC_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Saturate the programmed count to the table depth.
  assign count_ext = CC_W'(count_q);
  assign n_act     = (count_ext > CC_W'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS) : CNT_W'(count_ext);
  assign cnt_last  = (cnt_q == IDX_W'(n_act - CNT_W'(1)));
  assign out_free  = !m_valid_q || m_axis_tready;

  assign tt_addr = (state_q == ST_UPD_RD) ? best_idx : cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser && (32'(in_idx) < MAX_SERVERS)) begin
      tt_mem[IDX_W'(in_idx)] <= in_svc;
    end
    tt_rd_q <= tt_mem[tt_addr];
  end

  always_comb begin
    ft_ctrl.wr_en = (state_q == ST_INIT_WR) || (state_q == ST_UPD_WR);
    ft_ctrl.rd_en = (state_q == ST_SCAN);
    ft_wr_addr    = (state_q == ST_INIT_WR) ? cnt_q : best_idx;
    // Advance the picked server by its service time; init writes the service time alone.
    ft_wr_data    = (state_q == ST_INIT_WR) ? FT_W'(tt_rd_q) : best_val + FT_W'(tt_rd_q);
  end

  efsa_ftmem #(
    .MAX_SERVERS (MAX_SERVERS),
    .FT_W        (FT_W)
  ) u_ftmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ft_ctrl),
    .wr_addr_i  (ft_wr_addr),
    .wr_data_i  (ft_wr_data),
    .rd_addr_i  (cnt_q),
    .best_idx_o (best_idx),
    .best_val_o (best_val)
  );

  assign best_ext = EX_W'(best_val);
  assign best_sat = (best_ext > EX_W'(WAIT_MAX)) ? WAIT_MAX : best_ext[WAIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rounds_q  <= '0;
      direct_q  <= 1'b0;
      none_q    <= 1'b0;
      res_idx_q <= '0;
      m_valid_q <= 1'b0;
      m_srv_q   <= '0;
      m_wait_q  <= '0;
      m_none_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && !((state_q == ST_DONE) && out_free)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser) begin
            cnt_q <= '0;
            if (n_act == '0) begin
              direct_q  <= 1'b1;
              none_q    <= 1'b1;
              res_idx_q <= '0;
              state_q   <= ST_DONE;
            end else if (PC_W'(in_pos) < PC_W'(n_act)) begin
              direct_q  <= 1'b1;
              none_q    <= 1'b0;
              res_idx_q <= IDX_W'(in_pos);
              state_q   <= ST_DONE;
            end else begin
              direct_q <= 1'b0;
              none_q   <= 1'b0;
              rounds_q <= in_pos - POSITION_BITS'(n_act);
              state_q  <= ST_INIT_RD;
            end
          end
        end
        ST_INIT_RD: begin
          state_q <= ST_INIT_WR;
        end
        ST_INIT_WR: begin
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end else begin
            cnt_q   <= cnt_q + IDX_W'(1);
            state_q <= ST_INIT_RD;
          end
        end
        ST_SCAN: begin
          if (cnt_last) begin
            state_q <= ST_SCAN_DONE;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        ST_SCAN_DONE: begin
          // Last compare lands this cycle; the minimum is final next cycle.
          state_q <= (rounds_q == '0) ? ST_DONE : ST_UPD_RD;
        end
        ST_UPD_RD: begin
          state_q <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          rounds_q <= rounds_q - POSITION_BITS'(1);
          cnt_q    <= '0;
          state_q  <= ST_SCAN;
        end
        ST_DONE: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_none_q  <= none_q;
            m_srv_q   <= direct_q ? SRV_W'(res_idx_q) : SRV_W'(best_idx);
            m_wait_q  <= direct_q ? '0 : best_sat;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({m_wait_q, m_srv_q});
  assign m_axis_tuser  = m_none_q;

  `EFSA_ASSERT(a_zero_count_direct, clk_i, rst_ni,
    (in_acc && s_axis_tuser && (n_act == '0)) |=> (state_q == ST_DONE) && direct_q && none_q,
    "query with no servers did not take the direct path")
  `EFSA_ASSERT(a_none_result_zero, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0),
    "no-servers result carries a non-zero server or wait")
  `EFSA_ASSERT(a_update_has_round, clk_i, rst_ni,
    (state_q == ST_UPD_WR) |-> (rounds_q != '0),
    "finish time advanced with no round left")
  `EFSA_ASSERT(a_scan_in_range, clk_i, rst_ni,
    (state_q == ST_SCAN) |-> (CNT_W'(cnt_q) < n_act),
    "scan index beyond the active servers")

endmodule

FILE: test/tb.sv
// Self-checking bench for earliest_free_server_assignment_unit: directed table, then random bursts.
// Needs efsa_pkg and the unit; keeps its own wait-time predictor and a queue of pending answers.
`timescale 1ns / 100ps
module tb;
  import efsa_pkg::*;

  localparam int unsigned POS_W      = POSITION_BITS_DEF;
  localparam int unsigned IN_W       = ((SRV_W + SVC_W + POS_W + 7) / 8) * 8;
  localparam int unsigned OUT_W      = ((SRV_W + WAIT_W + 7) / 8) * 8;
  localparam int unsigned IDLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 558;

  typedef enum logic {ACT_LOAD = 1'b0, ACT_QUERY = 1'b1} action_e;
  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_e;

  typedef struct packed {
    logic [SRV_W-1:0]  server;
    logic [WAIT_W-1:0] queue_delay;
    logic              none;
  } answer_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_W-1:0]  count;
    logic [SRV_W-1:0]  idx;
    logic [SVC_W-1:0]  svc;
    logic [POS_W-1:0]  pos;
    logic              typed;
    answer_t           want;
  } stim_row_t;

  localparam int unsigned N_ROWS = 29;

  // Typed answers only where obvious: no servers, or position below the count.
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_QUERY, 5'd0,  4'd0,  16'd0,     20'd0,       1'b1, '{4'd0,  36'd0, 1'b1}},
    '{ROW_QUERY, 5'd0,  4'hF,  16'hFFFF,  20'hFFFFF,   1'b1, '{4'd0,  36'd0, 1'b1}},
    '{ROW_LOAD,  5'd0,  4'd0,  16'hFFFF,  20'hAAAAA,   1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd1,  16'd3,     20'h55555,   1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd2,  16'd7,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd3,  16'd2,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd4,  16'd5,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd5,  16'd11,    20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd6,  16'd4,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd7,  16'd9,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd8,  16'd6,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd9,  16'd13,    20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd10, 16'd8,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd11, 16'd10,    20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd12, 16'd12,    20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd13, 16'd1,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd14, 16'd14,    20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd15, 16'd0,     20'hFFFFF,   1'b0, '0},
    '{ROW_CFG,   5'd1,  4'd0,  16'd0,     20'd0,       1'b0, '0},
    '{ROW_QUERY, 5'd0,  4'd0,  16'd0,     20'd0,       1'b1, '{4'd0,  36'd0, 1'b0}},
    '{ROW_QUERY, 5'd0,  4'd0,  16'd0,     20'd40000,   1'b0, '0},
    '{ROW_CFG,   5'd31, 4'd0,  16'd0,     20'd0,       1'b0, '0},
    '{ROW_QUERY, 5'd0,  4'd0,  16'd0,     20'd15,      1'b1, '{4'd15, 36'd0, 1'b0}},
    '{ROW_QUERY, 5'd0,  4'd0,  16'd0,     20'd16,      1'b0, '0},
    '{ROW_CFG,   5'd16, 4'd0,  16'd0,     20'd0,       1'b0, '0},
    '{ROW_LOAD,  5'd0,  4'd15, 16'hFFFF,  20'd0,       1'b0, '0},
    '{ROW_QUERY, 5'd0,  4'd0,  16'd0,     20'd200,     1'b0, '0},
    '{ROW_CFG,   5'd0,  4'd0,  16'd0,     20'd0,       1'b0, '0},
    '{ROW_QUERY, 5'd0,  4'd0,  16'd0,     20'd5,       1'b1, '{4'd0,  36'd0, 1'b1}}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;   // server_index, service_time, position
  logic             s_axis_tuser  = 1'b0; // action
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;         // assigned_server, queue_delay
  logic             m_axis_tuser;         // no_servers

  // Predictor copy of the block's state.
  logic [CFG_W-1:0] count_model = '0;
  logic [SVC_W-1:0] service_model [MAX_SERVERS_DEF];
  longint unsigned  finish_model  [MAX_SERVERS_DEF];

  answer_t     pending_answers [$];
  answer_t     head_answer;
  logic        calm = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned loads_sent = 0, queries_sent = 0, empty_answers = 0, count_writes = 0;
  int unsigned answers_checked = 0, idle_cycles = 0;

  earliest_free_server_assignment_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_earliest(int unsigned n);
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (finish_model[i] < finish_model[best]) best = i;
    end
    return best;
  endfunction

  function automatic answer_t predict_assignment(logic [POS_W-1:0] pos);
    answer_t         ans;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     rounds;
    longint unsigned soonest;
    ans = '0;
    n = (count_model > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : count_model;
    if (n == 0) begin
      ans.none = 1'b1;
      return ans;
    end
    if (pos < n) begin
      ans.server = pos[SRV_W-1:0];
      return ans;
    end
    for (int unsigned i = 0; i < n; i++) finish_model[i] = service_model[i];
    rounds = pos - n;
    repeat (rounds) begin
      pick = pick_earliest(n);
      finish_model[pick] += service_model[pick];
    end
    pick = pick_earliest(n);
    soonest = finish_model[pick];
    ans.server = pick[SRV_W-1:0];
    ans.queue_delay = (soonest > WAIT_MAX) ? WAIT_MAX : soonest[WAIT_W-1:0];
    return ans;
  endfunction

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // Change the server count only once the unit is idle.
  task automatic write_count(logic [CFG_W-1:0] value);
    drain_results();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    count_model = value;
    count_writes++;
  endtask

  task automatic send_request(action_e act, logic [SRV_W-1:0] idx, logic [SVC_W-1:0] svc,
                              logic [POS_W-1:0] pos, logic typed, answer_t want);
    answer_t ans;
    if (!calm && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= IN_W'({pos, svc, idx});
    do @(posedge clk_i); while (!s_axis_tready);
    // Request taken at this edge: update the predictor now.
    if (act == ACT_LOAD) begin
      service_model[idx] = svc;
      loads_sent++;
    end else begin
      ans = typed ? want : predict_assignment(pos);
      if (ans.none) empty_answers++;
      pending_answers.push_back(ans);
      queries_sent++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected answer: server %0d wait %0d none %0b",
                   m_axis_tdata[SRV_W-1:0], m_axis_tdata[SRV_W +: WAIT_W], m_axis_tuser);
        mismatch_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        answers_checked++;
        if (m_axis_tdata[SRV_W-1:0] !== head_answer.server ||
            m_axis_tdata[SRV_W +: WAIT_W] !== head_answer.queue_delay ||
            m_axis_tuser !== head_answer.none) begin
          if (mismatch_count < 10)
            $display("mismatch: want server %0d wait %0d none %0b, got server %0d wait %0d none %0b",
                     head_answer.server, head_answer.queue_delay, head_answer.none,
                     m_axis_tdata[SRV_W-1:0], m_axis_tdata[SRV_W +: WAIT_W], m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d answers pending", pending_answers.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      burst;
    int unsigned      n_active;
    logic [CFG_W-1:0] count_pick;
    logic [SRV_W-1:0] r_idx;
    logic [SVC_W-1:0] r_svc;
    logic [POS_W-1:0] r_pos;
    sent = 0;
    phase = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < N_ROWS; i++) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          write_count(directed_rows[i].count);
        end
        ROW_LOAD: begin
          send_request(ACT_LOAD, directed_rows[i].idx, directed_rows[i].svc,
                       directed_rows[i].pos, 1'b0, '0);
        end
        default: begin
          send_request(ACT_QUERY, directed_rows[i].idx, directed_rows[i].svc,
                       directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].want);
        end
      endcase
    end

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       count_pick = '0;
        1:       count_pick = CFG_W'($urandom_range(16, 31));
        2, 3, 4: count_pick = CFG_W'($urandom_range(1, 16));
        default: count_pick = CFG_W'($urandom_range(1, 4));
      endcase
      write_count(count_pick);
      n_active = (count_model > MAX_SERVERS_DEF) ? MAX_SERVERS_DEF : count_model;
      calm = (phase >= 8 && phase < 12);
      burst = $urandom_range(10, 40);
      for (int unsigned k = 0; k < burst; k++) begin
        // Hold the sender once until every pending answer is out.
        if (phase == 5 && k == burst / 2) drain_results();
        r_idx = SRV_W'($urandom);
        r_pos = POS_W'($urandom);
        case ($urandom_range(0, 9))
          0:       r_svc = '0;
          1:       r_svc = '1;
          2, 3, 4: r_svc = SVC_W'($urandom_range(1, 15));
          default: r_svc = SVC_W'($urandom);
        endcase
        if ($urandom_range(0, 99) < 35) begin
          send_request(ACT_LOAD, r_idx, r_svc, r_pos, 1'b0, '0);
        end else begin
          // Keep the scan short: few rounds beyond the server count.
          if (n_active != 0) begin
            if ($urandom_range(0, 9) < 2)
              r_pos = POS_W'($urandom_range(0, n_active - 1));
            else
              r_pos = POS_W'(n_active + $urandom_range(0, 2400 / (n_active + 3)));
          end
          send_request(ACT_QUERY, r_idx, r_svc, r_pos, 1'b0, '0);
        end
        sent++;
      end
      phase++;
    end

    calm = 1'b0;
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("covered %0d loads and %0d queries (%0d with no servers) over %0d count writes",
             loads_sent, queries_sent, empty_answers, count_writes);
    $display("%0d answers checked, %0d failures", answers_checked, mismatch_count);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
